// ===== src/bcu_pkg.sv =====
// shared types, constants and weight table for the bicubic upscaler
`default_nettype none
package bcu_pkg;
    localparam int MAX_IN_WIDTH     = 256;
    localparam int MAX_IN_HEIGHT    = 256;
    localparam int WEIGHT_FRAC_BITS = 14;
    localparam int COL_W  = $clog2(MAX_IN_WIDTH);
    localparam int ROW_W  = $clog2(MAX_IN_HEIGHT);
    localparam int ADDR_W = COL_W + ROW_W;
    localparam int WGT_W  = WEIGHT_FRAC_BITS + 3;
    localparam int PROD_W = 2 * WGT_W;
    localparam int ACC_W  = PROD_W + 8 + 4;

    localparam logic [1:0] REG_IN_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IN_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_OUT_WIDTH  = 2'd2;
    localparam logic [1:0] REG_OUT_HEIGHT = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE, ST_NEAR_RD, ST_NEAR_OUT, ST_TAP, ST_DRAIN, ST_DONE, ST_OOR
    } t_state;

    typedef struct packed {
        logic load;
        logic capture;
        logic tap_rd;
        logic acc_clr;
        logic out_near;
        logic out_cubic;
        logic out_oor;
    } t_cmd;

    typedef struct packed {
        logic is_load;
        logic is_oor;
        logic is_cubic;
        logic last_tap;
    } t_status;

    function automatic logic signed [WGT_W-1:0] kernel_weight(
        input logic [1:0] phase, input logic [1:0] tap);
        logic signed [12:0] n;
        logic signed [31:0] m;
        logic signed [31:0] r;
        n = 13'sd0;
        case ({phase, tap})
            4'h0: n = -13'sd147;  4'h1: n = 13'sd1981; 4'h2: n = 13'sd235;  4'h3: n = -13'sd21;
            4'h4: n = -13'sd225;  4'h5: n = 13'sd1535; 4'h6: n = 13'sd873;  4'h7: n = -13'sd135;
            4'h8: n = -13'sd135;  4'h9: n = 13'sd873;  4'ha: n = 13'sd1535; 4'hb: n = -13'sd225;
            4'hc: n = -13'sd21;   4'hd: n = 13'sd235;  4'he: n = 13'sd1981; 4'hf: n = -13'sd147;
            default: n = 13'sd0;
        endcase
        if (WEIGHT_FRAC_BITS >= 11) begin
            r = 32'(n) <<< (WEIGHT_FRAC_BITS - 11);
        end else begin
            m = (n < 0) ? -32'(n) : 32'(n);
            m = (m + (32'sd1 <<< (10 - WEIGHT_FRAC_BITS))) >>> (11 - WEIGHT_FRAC_BITS);
            r = (n < 0) ? -m : m;
        end
        return WGT_W'(r);
    endfunction
endpackage
`default_nettype wire

// ===== src/bicubic_upscale_x4_rgb_top.sv =====
// top level of the 4x rgb bicubic upscaler
// A transaction is taken when start is high and busy low. A load ends in the done state,
// an out-of-range request in the out-of-range state, a border request in a nearest read,
// and an interior request in sixteen tap reads and a drain: the neighbour pixels come from
// the single frame memory read port, one per cycle, into one shared multiply-accumulate.
// The result shows for one cycle with o_valid and cannot be stalled; a new transaction can
// be taken in the cycle that shows it. Frame memory is not cleared.
`default_nettype none
module bicubic_upscale_x4_rgb_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_operation,
    input  wire logic [11:0] i_coord_x,
    input  wire logic [11:0] i_coord_y,
    input  wire logic [7:0]  i_red_in,
    input  wire logic [7:0]  i_green_in,
    input  wire logic [7:0]  i_blue_in,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data,
    output logic             o_valid,
    output logic [7:0]       o_red_out,
    output logic [7:0]       o_green_out,
    output logic [7:0]       o_blue_out,
    output logic             o_used_bicubic,
    output logic             o_out_of_range
);
    import bcu_pkg::*;
    t_cmd    cmd;
    t_status status;
    logic    ctl_busy;
    logic [8:0]  r_in_width, r_in_height;
    logic [12:0] r_out_width, r_out_height;

    assign o_cfg_ready = 1'b1;
    assign busy = ctl_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width <= 9'd256;
            r_in_height <= 9'd256;
            r_out_width <= 13'd1024;
            r_out_height <= 13'd1024;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IN_WIDTH:   r_in_width <= i_cfg_data[8:0];
                REG_IN_HEIGHT:  r_in_height <= i_cfg_data[8:0];
                REG_OUT_WIDTH:  r_out_width <= i_cfg_data;
                REG_OUT_HEIGHT: r_out_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bcu_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
        .i_status(status), .o_cmd(cmd), .o_busy(ctl_busy)
    );

    bcu_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_operation(i_operation), .i_coord_x(i_coord_x), .i_coord_y(i_coord_y),
        .i_red_in(i_red_in), .i_green_in(i_green_in), .i_blue_in(i_blue_in),
        .i_in_width(r_in_width), .i_in_height(r_in_height),
        .i_out_width(r_out_width), .i_out_height(r_out_height),
        .o_status(status), .o_valid(o_valid),
        .o_red_out(o_red_out), .o_green_out(o_green_out), .o_blue_out(o_blue_out),
        .o_used_bicubic(o_used_bicubic), .o_out_of_range(o_out_of_range)
    );
endmodule
`default_nettype wire

// ===== src/bcu_ctrl.sv =====
// controller state machine sequencing loads, nearest reads, tap reads and out-of-range results
`default_nettype none
module bcu_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire bcu_pkg::t_status i_status,
    output bcu_pkg::t_cmd         o_cmd,
    output logic                  o_busy
);
    import bcu_pkg::*;
    t_state r_state, n_state;
    logic [1:0] r_drain, n_drain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_drain <= n_drain;
        end
    end

    always_comb begin
        n_state = r_state;
        n_drain = r_drain;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.is_load) n_state = ST_IDLE;
                else if (i_status.is_oor) n_state = ST_OOR;
                else if (i_status.is_cubic) n_state = ST_TAP;
                else n_state = ST_NEAR_RD;
            end
            ST_NEAR_RD:  n_state = ST_NEAR_OUT;
            ST_NEAR_OUT: n_state = ST_IDLE;
            ST_TAP: begin
                if (i_status.last_tap) begin
                    n_state = ST_DRAIN;
                    n_drain = 2'd3;
                end
            end
            ST_DRAIN: begin
                if (r_drain == 2'd0) n_state = ST_IDLE;
                else n_drain = r_drain - 2'd1;
            end
            ST_OOR:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE:     o_cmd.capture = i_start;
            ST_DONE: begin
                o_cmd.load = i_status.is_load;
                o_cmd.acc_clr = 1'b1;
            end
            ST_NEAR_OUT: o_cmd.out_near = 1'b1;
            ST_TAP:      o_cmd.tap_rd = 1'b1;
            ST_DRAIN:    o_cmd.out_cubic = (r_drain == 2'd0);
            ST_OOR:      o_cmd.out_oor = 1'b1;
            default:     o_cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

// ===== src/bcu_datapath.sv =====
// frame memory, address generation and shared multiply-accumulate
`default_nettype none
module bcu_datapath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bcu_pkg::t_cmd    i_cmd,
    input  wire logic             i_operation,
    input  wire logic [11:0]      i_coord_x,
    input  wire logic [11:0]      i_coord_y,
    input  wire logic [7:0]       i_red_in,
    input  wire logic [7:0]       i_green_in,
    input  wire logic [7:0]       i_blue_in,
    input  wire logic [8:0]       i_in_width,
    input  wire logic [8:0]       i_in_height,
    input  wire logic [12:0]      i_out_width,
    input  wire logic [12:0]      i_out_height,
    output bcu_pkg::t_status      o_status,
    output logic                  o_valid,
    output logic [7:0]            o_red_out,
    output logic [7:0]            o_green_out,
    output logic [7:0]            o_blue_out,
    output logic                  o_used_bicubic,
    output logic                  o_out_of_range
);
    import bcu_pkg::*;
    logic [23:0] r_mem [0:(1<<ADDR_W)-1];
    logic        r_op;
    logic [11:0] r_cx, r_cy;
    logic [23:0] r_pix_in;
    logic [3:0]  r_tap;
    logic        r_tap_v;
    logic [23:0] r_rd;
    logic signed [PROD_W-1:0] r_wgt, n_wgt;
    logic signed [ACC_W-1:0] r_acc [0:2];
    logic [7:0]  r_red, r_green, r_blue;
    logic        r_valid, r_cubic, r_oor;

    // saturated sizes
    logic [10:0] w, h;
    always_comb begin
        w = (i_in_width == 9'd0) ? 11'd1 :
            (i_in_width > 9'(MAX_IN_WIDTH)) ? 11'(MAX_IN_WIDTH) : 11'(i_in_width);
        if (MAX_IN_WIDTH > 511) w = (i_in_width == 9'd0) ? 11'd1 : 11'(i_in_width);
        h = (i_in_height == 9'd0) ? 11'd1 :
            (i_in_height > 9'(MAX_IN_HEIGHT)) ? 11'(MAX_IN_HEIGHT) : 11'(i_in_height);
        if (MAX_IN_HEIGHT > 511) h = (i_in_height == 9'd0) ? 11'd1 : 11'(i_in_height);
    end

    logic [12:0] px, py;
    logic [9:0]  bx, by, nx, ny;
    logic [1:0]  phx, phy;
    logic        oor, cubic, ld_ok;
    always_comb begin
        px = {r_cx, 1'b0} - 13'd3;
        py = {r_cy, 1'b0} - 13'd3;
        bx = px[12:3];
        by = py[12:3];
        phx = px[2:1];
        phy = py[2:1];
        nx = (r_cx < 12'd2) ? 10'd0 : bx;
        ny = (r_cy < 12'd2) ? 10'd0 : by;
        if (11'(nx) > w - 11'd1) nx = 10'(w - 11'd1);
        if (11'(ny) > h - 11'd1) ny = 10'(h - 11'd1);
        oor = (13'(r_cx) >= i_out_width) || (13'(r_cy) >= i_out_height);
        cubic = (r_cx >= 12'd8) && (14'(r_cx) + 14'd9 <= {1'b0, w, 2'b00})
             && (r_cy >= 12'd8) && (14'(r_cy) + 14'd9 <= {1'b0, h, 2'b00});
        ld_ok = (13'(r_cx) < 13'(w)) && (13'(r_cy) < 13'(h));
    end
    assign o_status.is_load  = !r_op;
    assign o_status.is_oor   = oor;
    assign o_status.is_cubic = cubic;
    assign o_status.last_tap = (r_tap == 4'hf);

    logic [9:0] tcol, trow;
    logic [ADDR_W-1:0] rd_addr;
    always_comb begin
        tcol = bx - 10'd1 + 10'(r_tap[3:2]);
        trow = by - 10'd1 + 10'(r_tap[1:0]);
        if (i_cmd.tap_rd) rd_addr = {trow[ROW_W-1:0], tcol[COL_W-1:0]};
        else rd_addr = {ny[ROW_W-1:0], nx[COL_W-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && ld_ok) r_mem[{r_cy[ROW_W-1:0], r_cx[COL_W-1:0]}] <= r_pix_in;
        r_rd <= r_mem[rd_addr];
    end

    always_comb begin
        n_wgt = PROD_W'(kernel_weight(phx, r_tap[3:2])) * PROD_W'(kernel_weight(phy, r_tap[1:0]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap <= '0;
            r_tap_v <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_tap_v <= i_cmd.tap_rd;
            r_valid <= i_cmd.out_near || i_cmd.out_cubic || i_cmd.out_oor;
            if (i_cmd.acc_clr) r_tap <= '0;
            else if (i_cmd.tap_rd) r_tap <= r_tap + 4'd1;
        end
    end

    logic signed [ACC_W-1:0] top;
    assign top = ACC_W'(255) <<< (2 * WEIGHT_FRAC_BITS);

    function automatic logic [7:0] clamp(input logic signed [ACC_W-1:0] s,
                                         input logic signed [ACC_W-1:0] t);
        logic [ACC_W-1:0] v;
        v = s >>> (2 * WEIGHT_FRAC_BITS);
        if (s < 0) return 8'd0;
        if (s > t) return 8'd255;
        return v[7:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_operation;
            r_cx <= i_coord_x;
            r_cy <= i_coord_y;
            r_pix_in <= {i_blue_in, i_green_in, i_red_in};
        end
        if (i_cmd.tap_rd) r_wgt <= n_wgt;
        if (i_cmd.acc_clr) begin
            for (int c = 0; c < 3; c++) r_acc[c] <= '0;
        end else if (r_tap_v) begin
            for (int c = 0; c < 3; c++)
                r_acc[c] <= r_acc[c] + ACC_W'(r_wgt) *
                            ACC_W'($signed({1'b0, r_rd[8*c +: 8]}));
        end
        if (i_cmd.out_near) begin
            {r_blue, r_green, r_red} <= r_rd;
            r_cubic <= 1'b0;
            r_oor <= 1'b0;
        end else if (i_cmd.out_cubic) begin
            r_red <= clamp(r_acc[0], top);
            r_green <= clamp(r_acc[1], top);
            r_blue <= clamp(r_acc[2], top);
            r_cubic <= 1'b1;
            r_oor <= 1'b0;
        end else if (i_cmd.out_oor) begin
            {r_blue, r_green, r_red} <= '0;
            r_cubic <= 1'b0;
            r_oor <= 1'b1;
        end
    end

    assign o_valid = r_valid;
    assign o_red_out = r_red;
    assign o_green_out = r_green;
    assign o_blue_out = r_blue;
    assign o_used_bicubic = r_cubic;
    assign o_out_of_range = r_oor;
endmodule
`default_nettype wire

// ===== src/bcu_checker.sv =====
// port-level checks for the upscaler, bound to the top level
`default_nettype none
module bcu_port_checks (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_valid,
    input wire logic [7:0] o_red_out,
    input wire logic       o_used_bicubic,
    input wire logic       o_out_of_range
);
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("busy not raised");
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_used_bicubic && o_out_of_range)) else $error("both flags");
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_of_range) |-> (o_red_out == 8'd0)) else $error("oor data");
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("repeated result");
endmodule

bind bicubic_upscale_x4_rgb_top bcu_port_checks u_bcu_port_checks (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_red_out(o_red_out),
    .o_used_bicubic(o_used_bicubic), .o_out_of_range(o_out_of_range)
);
`default_nettype wire
